// File: hw/rtl/txcw_pkg.sv
package txcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 16;
  localparam int QDEPTH  = 2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic [7:0] BLANK_CODE   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0f;

  // action codes on the request port
  localparam logic [2:0] ACT_PUT    = 3'd0;
  localparam logic [2:0] ACT_BACK   = 3'd1;
  localparam logic [2:0] ACT_CLEAR  = 3'd2;
  localparam logic [2:0] ACT_SETPOS = 3'd3;
  localparam logic [2:0] ACT_READ   = 3'd4;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_BACK,
    OP_CLEAR,
    OP_SETPOS,
    OP_READ,
    OP_REPORT
  } txcw_op_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       char_code;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
  } txcw_req_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
  } txcw_rsp_t;

  // classified item as it sits in the queue
  typedef struct packed {
    txcw_op_e         op;
    logic [7:0]       char_code;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [7:0]       attr;
  } txcw_entry_t;

  typedef struct packed {
    logic init_busy;
  } txcw_status_t;

endpackage

// File: hw/rtl/text_console_writer.sv
// Text console writer: 80x25 cells of character and attribute with a cursor.
//
// Request: drive req_i and raise start; the item is taken at a clock edge
// where start is high and busy is low. Items go into a two-entry queue, so
// a few may be taken while earlier ones are still being carried out.
// Result: one per item, in order, on rsp_o for the single cycle that
// strobe_o is high. There is no back-pressure on the result side.
// Attribute: written on cfg_* (valid/ready, ready always high); each item
// takes the attribute in force when it is accepted.
//
// From acceptance an item waits in the queue, is popped in the idle state and
// carried out in the execute state; its result is registered. A cell read adds
// a read state, a scrolling character first blanks one row a cell a cycle, and
// clear blanks the whole store. A new item is popped only once the last is done.
// Scrolling rotates the row order rather than moving cells.
//
// Reset: cursor homes and the store is blanked with attribute 0x0f by a
// pass over all CELLS (2000) cells, during which busy stays high; attribute
// writes are still taken.
module text_console_writer
  import txcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  txcw_req_t  req_i,
  output logic       strobe_o,
  output txcw_rsp_t  rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_wdata_i
);

  txcw_status_t       status;
  logic               q_ready, q_push, q_valid, q_pop;
  txcw_entry_t        q_in, q_head;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  txcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .q_ready_i   (q_ready),
    .q_valid_o   (q_push),
    .q_entry_o   (q_in)
  );

  txcw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (q_in),
    .ready_o      (q_ready),
    .valid_o      (q_valid),
    .head_o       (q_head),
    .pop_i        (q_pop)
  );

  txcw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .status_o    (status),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .strobe_o    (strobe_o),
    .rsp_o       (rsp_o)
  );

  txcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// File: hw/rtl/txcw_ram.sv
module txcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/txcw_front.sv
module txcw_front
  import txcw_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  txcw_req_t    req_i,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_wdata_i,
  input  txcw_status_t status_i,
  input  logic         q_ready_i,
  output logic         q_valid_o,
  output txcw_entry_t  q_entry_o
);

  logic [7:0] attr_q, attr_d;

  assign cfg_ready_o = 1'b1;
  assign busy        = !q_ready_i || status_i.init_busy;
  assign q_valid_o   = start && !busy;

  always_comb begin
    attr_d = attr_q;
    if (cfg_valid_i && cfg_ready_o) begin
      attr_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else begin
      attr_q <= attr_d;
    end
  end

  // attribute travels with the item so a later register write cannot touch it
  always_comb begin
    q_entry_o.op        = OP_REPORT;
    q_entry_o.char_code = req_i.char_code;
    q_entry_o.column    = req_i.column;
    q_entry_o.row       = req_i.row;
    q_entry_o.attr      = attr_q;
    case (req_i.action)
      ACT_PUT: begin
        q_entry_o.op = (req_i.char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      end
      ACT_BACK:  q_entry_o.op = OP_BACK;
      ACT_CLEAR: q_entry_o.op = OP_CLEAR;
      ACT_SETPOS: begin
        q_entry_o.op = OP_SETPOS;
        if (req_i.column > COL_W'(COLUMNS)) q_entry_o.column = COL_W'(COLUMNS);
        if (req_i.row > ROW_W'(ROWS))       q_entry_o.row    = ROW_W'(ROWS);
      end
      ACT_READ: begin
        // out-of-store read just reports the cursor with a zero cell
        if (req_i.column < COL_W'(COLUMNS) && req_i.row < ROW_W'(ROWS)) begin
          q_entry_o.op = OP_READ;
        end
      end
      default: q_entry_o.op = OP_REPORT;
    endcase
  end

endmodule

// File: hw/rtl/txcw_fifo.sv
module txcw_fifo
  import txcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  txcw_entry_t push_entry_i,
  output logic        ready_o,
  output logic        valid_o,
  output txcw_entry_t head_o,
  input  logic        pop_i
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  txcw_entry_t        slot_q [QDEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign ready_o = cnt_q != CNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = slot_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_entry_i;
    end
  end

endmodule

// File: hw/rtl/txcw_back.sv
module txcw_back
  import txcw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  txcw_entry_t         q_head_i,
  output logic                q_pop_o,
  output txcw_status_t        status_o,
  output logic                ram_we_o,
  output logic [ADDR_W-1:0]   ram_waddr_o,
  output logic [CELL_W-1:0]   ram_wdata_o,
  output logic                ram_re_o,
  output logic [ADDR_W-1:0]   ram_raddr_o,
  input  logic [CELL_W-1:0]   ram_rdata_i,
  output logic                strobe_o,
  output txcw_rsp_t           rsp_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_PUTWR,
    S_READ
  } state_e;

  localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);

  state_e             state_q, state_d;
  txcw_entry_t        cur_q, cur_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   line_q, line_d;
  logic [ROW_W-1:0]   top_q, top_d;      // physical row holding logical row 0
  logic [ADDR_W-1:0]  swp_addr_q, swp_addr_d;
  logic [ADDR_W-1:0]  swp_end_q, swp_end_d;
  logic               swp_clr_q, swp_clr_d;
  logic               strobe_q, strobe_d;
  txcw_rsp_t          rsp_q, rsp_d;

  logic               emit;
  logic [CELL_W-1:0]  rd_cell;
  logic [COL_W-1:0]   pcol, bcol;
  logic [ROW_W-1:0]   pline, bline;
  logic [ADDR_W-1:0   ] scr_base;

  // rows rotate instead of moving, so a scroll only blanks one row
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c,
                                                  input logic [ROW_W-1:0] t);
    logic [ROW_W:0] p;
    p = {1'b0, r} + {1'b0, t};
    if (p >= ROWS_X) p = p - ROWS_X;
    return ADDR_W'(p) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  // cursor after a pending wrap, and after a backspace
  always_comb begin
    pcol  = col_q;
    pline = line_q;
    if (col_q >= COL_W'(COLUMNS)) begin
      pcol  = '0;
      pline = (line_q < ROW_W'(ROWS)) ? line_q + ROW_W'(1) : line_q;
    end
    bcol  = '0;
    bline = '0;
    if (col_q != '0) begin
      bcol  = col_q - COL_W'(1);
      bline = line_q;
    end else if (line_q != '0) begin
      bcol  = COL_W'(COLUMNS - 1);
      bline = line_q - ROW_W'(1);
    end
  end

  assign scr_base = cell_addr('0, '0, top_q);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    col_d       = col_q;
    line_d      = line_q;
    top_d       = top_q;
    swp_addr_d  = swp_addr_q;
    swp_end_d   = swp_end_q;
    swp_clr_d   = swp_clr_q;
    rsp_d       = rsp_q;
    emit        = 1'b0;
    rd_cell     = '0;
    q_pop_o     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    case (state_q)
      S_INIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = swp_addr_q;
        ram_wdata_o = {ATTR_RESET, BLANK_CODE};
        swp_addr_d  = swp_addr_q + ADDR_W'(1);
        if (swp_addr_q == LAST_ADDR) begin
          swp_addr_d = '0;
          state_d    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cur_d   = q_head_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (cur_q.op)
          OP_NEWLINE: begin
            col_d  = '0;
            line_d = (line_q < ROW_W'(ROWS)) ? line_q + ROW_W'(1) : line_q;
            emit   = 1'b1;
          end
          OP_PUT: begin
            if (pline == ROW_W'(ROWS)) begin
              // new bottom row is the old top row
              top_d      = (top_q == ROW_W'(ROWS - 1)) ? '0 : top_q + ROW_W'(1);
              col_d      = pcol;
              line_d     = ROW_W'(ROWS - 1);
              swp_addr_d = scr_base;
              swp_end_d  = scr_base + ADDR_W'(COLUMNS - 1);
              swp_clr_d  = 1'b0;
              state_d    = S_SWEEP;
            end else begin
              ram_we_o    = 1'b1;
              ram_waddr_o = cell_addr(pline, pcol, top_q);
              ram_wdata_o = {cur_q.attr, cur_q.char_code};
              col_d       = pcol + COL_W'(1);
              line_d      = pline;
              emit        = 1'b1;
            end
          end
          OP_BACK: begin
            col_d  = bcol;
            line_d = bline;
            if (bline < ROW_W'(ROWS)) begin
              ram_we_o    = 1'b1;
              ram_waddr_o = cell_addr(bline, bcol, top_q);
              ram_wdata_o = {cur_q.attr, BLANK_CODE};
            end
            emit = 1'b1;
          end
          OP_CLEAR: begin
            swp_addr_d = '0;
            swp_end_d  = LAST_ADDR;
            swp_clr_d  = 1'b1;
            top_d      = '0;
            col_d      = '0;
            line_d     = '0;
            state_d    = S_SWEEP;
          end
          OP_SETPOS: begin
            col_d  = cur_q.column;
            line_d = cur_q.row;
            emit   = 1'b1;
          end
          OP_READ: begin
            ram_re_o    = 1'b1;
            ram_raddr_o = cell_addr(cur_q.row, cur_q.column, top_q);
            state_d     = S_READ;
          end
          default: emit = 1'b1;
        endcase
      end
      S_SWEEP: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = swp_addr_q;
        ram_wdata_o = {cur_q.attr, BLANK_CODE};
        swp_addr_d  = swp_addr_q + ADDR_W'(1);
        if (swp_addr_q == swp_end_q) begin
          if (swp_clr_q) begin
            emit    = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_PUTWR;
          end
        end
      end
      S_PUTWR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cell_addr(line_q, col_q, top_q);
        ram_wdata_o = {cur_q.attr, cur_q.char_code};
        col_d       = col_q + COL_W'(1);
        emit        = 1'b1;
        state_d     = S_IDLE;
      end
      S_READ: begin
        rd_cell = ram_rdata_i;
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    strobe_d = emit;
    if (emit) begin
      rsp_d.cursor_column = col_d;
      rsp_d.cursor_row    = line_d;
      rsp_d.cell_char     = rd_cell[7:0];
      rsp_d.cell_attr     = rd_cell[15:8];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cur_q      <= '0;
      col_q      <= '0;
      line_q     <= '0;
      top_q      <= '0;
      swp_addr_q <= '0;
      swp_end_q  <= '0;
      swp_clr_q  <= 1'b0;
      strobe_q   <= 1'b0;
      rsp_q      <= '0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      col_q      <= col_d;
      line_q     <= line_d;
      top_q      <= top_d;
      swp_addr_q <= swp_addr_d;
      swp_end_q  <= swp_end_d;
      swp_clr_q  <= swp_clr_d;
      strobe_q   <= strobe_d;
      rsp_q      <= rsp_d;
    end
  end

  assign status_o.init_busy = state_q == S_INIT;
  assign strobe_o           = strobe_q;
  assign rsp_o              = rsp_q;

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |=> !strobe_q)
    else $error("result strobe high on two cycles running");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_W'(COLUMNS) && line_q <= ROW_W'(ROWS))
    else $error("cursor outside its range");

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q < ROW_W'(ROWS))
    else $error("row rotation offset out of range");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_READ) |-> !ram_we_o)
    else $error("store written outside an item");

  a_pop_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == S_EXEC && !strobe_q)
    else $error("popped item not taken up");
`endif

endmodule
